// ----- src/qpq_pkg.sv -----
`default_nettype none

package qpq_pkg;

   // Number of quad corners, which is also the number of boundary edges.
   localparam int NUM_CORNERS = 4;

   // Width of the index that selects a corner.
   localparam int CORNER_IDX_WIDTH = 2;

   // Width of the nearest-edge result field.
   localparam int EDGE_WIDTH = 2;

   // Width of the register index on the configuration channel.
   localparam int CSR_ADDR_WIDTH = 8;

   // Register map of the configuration channel.
   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_CORNER_A = 8'd0,
      CSR_CORNER_B = 8'd1,
      CSR_CORNER_C = 8'd2,
      CSR_CORNER_D = 8'd3
   } qpq_csr_type;

endpackage

`default_nettype wire

// ----- src/qpq_if.sv -----
`default_nettype none

// Query word: one point, signed fixed point per coordinate.
interface qpq_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] query_x;
   logic signed [COORD_WIDTH-1:0] query_y;
   logic signed [COORD_WIDTH-1:0] query_z;

   modport source (output valid, output query_x, output query_y, output query_z,
                   input ready);
   modport sink   (input valid, input query_x, input query_y, input query_z,
                   output ready);
endinterface

// Result word: inside flag, nearest boundary point and its edge.
interface qpq_rsp_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic                          inside_quad;
   logic signed [COORD_WIDTH-1:0] nearest_x;
   logic signed [COORD_WIDTH-1:0] nearest_y;
   logic signed [COORD_WIDTH-1:0] nearest_z;
   logic [qpq_pkg::EDGE_WIDTH-1:0] nearest_edge;

   modport source (output valid, output inside_quad, output nearest_x, output nearest_y,
                   output nearest_z, output nearest_edge, input ready);
   modport sink   (input valid, input inside_quad, input nearest_x, input nearest_y,
                   input nearest_z, input nearest_edge, output ready);
endinterface

// Register write word: register index and packed corner data.
interface qpq_csr_if #(parameter int COORD_WIDTH = 16);
   logic                               valid;
   logic                               ready;
   logic [qpq_pkg::CSR_ADDR_WIDTH-1:0] addr;
   logic [3*COORD_WIDTH-1:0]           data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// ----- src/qpq_div_cell.sv -----
`default_nettype none

// One step of the multiply-divide: consumes one bit of the multiplier and
// produces one quotient bit step, keeping the remainder below the divisor.
module qpq_div_cell #(
   parameter int RW  = 36,
   parameter int MW  = 17,
   parameter int QW  = 17,
   parameter int BIT = 0
) (
   input  wire logic          clock,
   input  wire logic          enable,
   input  wire logic [RW-1:0] rem_prev,
   input  wire logic [QW-1:0] quo_prev,
   input  wire logic [RW-1:0] s_prev,
   input  wire logic [RW-1:0] l_prev,
   input  wire logic [MW-1:0] mag_prev,
   input  wire logic          neg_prev,
   output logic      [RW-1:0] rem_out,
   output logic      [QW-1:0] quo_out,
   output logic      [RW-1:0] s_out,
   output logic      [RW-1:0] l_out,
   output logic      [MW-1:0] mag_out,
   output logic               neg_out
);

   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [RW-1:0] s_ff, l_ff;
   logic [MW-1:0] mag_ff;
   logic          neg_ff;
   logic [RW-1:0] part, l2;
   logic          ge1, ge2;

   always_comb begin
      part = {rem_prev[RW-2:0], 1'b0} + (mag_prev[BIT] ? s_prev : '0);
      l2   = {l_prev[RW-2:0], 1'b0};
      ge1  = part >= l_prev;
      ge2  = part >= l2;
      if (ge2) begin
         rem_in = part - l2;
         quo_in = {quo_prev[QW-2:0], 1'b0} + QW'(2);
      end else if (ge1) begin
         rem_in = part - l_prev;
         quo_in = {quo_prev[QW-2:0], 1'b0} + QW'(1);
      end else begin
         rem_in = part;
         quo_in = {quo_prev[QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         s_ff   <= s_prev;
         l_ff   <= l_prev;
         mag_ff <= mag_prev;
         neg_ff <= neg_prev;
      end
   end

   assign rem_out = rem_ff;
   assign quo_out = quo_ff;
   assign s_out   = s_ff;
   assign l_out   = l_ff;
   assign mag_out = mag_ff;
   assign neg_out = neg_ff;

endmodule

`default_nettype wire

// ----- src/quad_point_query.sv -----
`default_nettype none

// Point-versus-quad query. Each request word carries one point; the block
// answers with an inside flag (parallelogram test at corner a along edges
// a-b and a-d) and the nearest point on the quad boundary with its edge
// number, lowest edge first on equal distance. The four corners are
// written through the register channel (index 0 to 3 for corners a to d)
// while no query is in flight; the user keeps to that, the block does not
// enforce it. While the output is not stalled, the pipeline takes one word
// per clock and returns one word per clock. The longest part of it is the
// projection divide, a row of COORD_WIDTH + 1 divide cells per edge and
// coordinate, each retiring one multiplier bit per cycle. The whole
// pipeline advances whenever the output register is empty or its word is
// being taken.
module quad_point_query #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   qpq_req_if.sink    req_chan,
   qpq_rsp_if.source  rsp_chan,
   qpq_csr_if.sink    csr_chan
);

   import qpq_pkg::*;

   localparam int W     = COORD_WIDTH;
   localparam int DW    = W + 1;       // coordinate difference
   localparam int EW    = W + 2;       // candidate before truncation
   localparam int PW    = 2 * W + 2;   // one product
   localparam int SW    = 2 * W + 4;   // dot products and distances
   localparam int NCELL = DW;          // one divide cell per multiplier bit
   localparam int LAST  = NCELL - 1;

   // Signed zero, so that sign tests on the dot products compare as signed.
   localparam logic signed [SW-1:0] SZERO = '0;

   // Corner registers and their unpacked coordinates.
   logic [3*W-1:0]       corner_ff [NUM_CORNERS];
   logic signed [W-1:0]  crd [NUM_CORNERS][3];

   // The whole pipeline moves together.
   logic adv;
   logic out_vld_ff;

   assign adv            = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CORNERS; i++) begin
            corner_ff[i] <= '0;
         end
      end else if (csr_chan.valid && (csr_chan.addr <= CSR_CORNER_D)) begin
         corner_ff[csr_chan.addr[CORNER_IDX_WIDTH-1:0]] <= csr_chan.data;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         for (int k = 0; k < 3; k++) begin
            crd[i][k] = corner_ff[i][k*W +: W];
         end
      end
   end

   // Stage 1: capture the query point.
   logic                v1_ff;
   logic signed [W-1:0] p1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff[0] <= req_chan.query_x;
         p1_ff[1] <= req_chan.query_y;
         p1_ff[2] <= req_chan.query_z;
      end
   end

   // Stage 2: differences. ap is point minus edge start, ed is the edge
   // vector, vv is corner d minus corner a for the inside test.
   logic                 v2_ff;
   logic signed [W-1:0]  p2_ff [3];
   logic signed [DW-1:0] ap2_ff [NUM_CORNERS][3];
   logic signed [DW-1:0] ed2_ff [NUM_CORNERS][3];
   logic signed [DW-1:0] vv2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            p2_ff[k]  <= p1_ff[k];
            vv2_ff[k] <= DW'(crd[NUM_CORNERS-1][k]) - DW'(crd[0][k]);
            for (int i = 0; i < NUM_CORNERS; i++) begin
               ap2_ff[i][k] <= DW'(p1_ff[k]) - DW'(crd[i][k]);
               ed2_ff[i][k] <= DW'(crd[(i + 1) % NUM_CORNERS][k]) - DW'(crd[i][k]);
            end
         end
      end
   end

   // Stage 3: products for the dot products.
   logic                 v3_ff;
   logic signed [W-1:0]  p3_ff [3];
   logic signed [PW-1:0] ps3_ff [NUM_CORNERS][3];
   logic signed [PW-1:0] pl3_ff [NUM_CORNERS][3];
   logic signed [PW-1:0] psv3_ff [3];
   logic signed [PW-1:0] plv3_ff [3];
   logic signed [DW-1:0] ed3_ff [NUM_CORNERS][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            p3_ff[k]   <= p2_ff[k];
            psv3_ff[k] <= PW'(ap2_ff[0][k]) * PW'(vv2_ff[k]);
            plv3_ff[k] <= PW'(vv2_ff[k]) * PW'(vv2_ff[k]);
            for (int i = 0; i < NUM_CORNERS; i++) begin
               ps3_ff[i][k] <= PW'(ap2_ff[i][k]) * PW'(ed2_ff[i][k]);
               pl3_ff[i][k] <= PW'(ed2_ff[i][k]) * PW'(ed2_ff[i][k]);
               ed3_ff[i][k] <= ed2_ff[i][k];
            end
         end
      end
   end

   // Stage 4: dot products, clamp decisions and the inside flag. The
   // divider only sees s when 0 < s < L; otherwise it gets zero and its
   // quotient is not used.
   logic                 v4_ff;
   logic signed [W-1:0]  p4_ff [3];
   logic                 ins4_ff;
   logic [SW-1:0]        sd4_ff [NUM_CORNERS];
   logic [SW-1:0]        l4_ff [NUM_CORNERS];
   logic                 lo4_ff [NUM_CORNERS];
   logic                 hi4_ff [NUM_CORNERS];
   logic [DW-1:0]        mag4_ff [NUM_CORNERS][3];
   logic                 neg4_ff [NUM_CORNERS][3];

   logic signed [SW-1:0] s_sum [NUM_CORNERS];
   logic signed [SW-1:0] l_sum [NUM_CORNERS];
   logic signed [SW-1:0] sv_sum, lv_sum;
   logic                 lo_dec [NUM_CORNERS];
   logic                 hi_dec [NUM_CORNERS];
   logic                 ins_dec;

   always_comb begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         s_sum[i]  = SW'(ps3_ff[i][0]) + SW'(ps3_ff[i][1]) + SW'(ps3_ff[i][2]);
         l_sum[i]  = SW'(pl3_ff[i][0]) + SW'(pl3_ff[i][1]) + SW'(pl3_ff[i][2]);
         lo_dec[i] = (l_sum[i] == '0) || (s_sum[i] <= SZERO);
         hi_dec[i] = !lo_dec[i] && (s_sum[i] >= l_sum[i]);
      end
      sv_sum  = SW'(psv3_ff[0]) + SW'(psv3_ff[1]) + SW'(psv3_ff[2]);
      lv_sum  = SW'(plv3_ff[0]) + SW'(plv3_ff[1]) + SW'(plv3_ff[2]);
      ins_dec = (s_sum[0] >= SZERO) && (s_sum[0] <= l_sum[0]) &&
                (sv_sum >= SZERO) && (sv_sum <= lv_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ins4_ff <= ins_dec;
         for (int k = 0; k < 3; k++) begin
            p4_ff[k] <= p3_ff[k];
         end
         for (int i = 0; i < NUM_CORNERS; i++) begin
            sd4_ff[i] <= (lo_dec[i] || hi_dec[i]) ? '0 : s_sum[i];
            l4_ff[i]  <= l_sum[i];
            lo4_ff[i] <= lo_dec[i];
            hi4_ff[i] <= hi_dec[i];
            for (int k = 0; k < 3; k++) begin
               mag4_ff[i][k] <= ed3_ff[i][k][DW-1] ? -ed3_ff[i][k] : ed3_ff[i][k];
               neg4_ff[i][k] <= ed3_ff[i][k][DW-1];
            end
         end
      end
   end

   // Divide rows: for each edge and coordinate, floor(|e| * s / L), one
   // multiplier bit per cell, most significant bit first.
   logic [SW-1:0] rem_w [NUM_CORNERS][3][NCELL];
   logic [DW-1:0] quo_w [NUM_CORNERS][3][NCELL];
   logic [SW-1:0] s_w   [NUM_CORNERS][3][NCELL];
   logic [SW-1:0] l_w   [NUM_CORNERS][3][NCELL];
   logic [DW-1:0] mag_w [NUM_CORNERS][3][NCELL];
   logic          neg_w [NUM_CORNERS][3][NCELL];

   for (genvar ge = 0; ge < NUM_CORNERS; ge++) begin : g_edge
      for (genvar gk = 0; gk < 3; gk++) begin : g_crd
         for (genvar gj = 0; gj < NCELL; gj++) begin : g_cell
            if (gj == 0) begin : g_head
               qpq_div_cell #(.RW(SW), .MW(DW), .QW(DW), .BIT(DW - 1)) u_cell (
                  .clock    (clock),
                  .enable   (adv),
                  .rem_prev ('0),
                  .quo_prev ('0),
                  .s_prev   (sd4_ff[ge]),
                  .l_prev   (l4_ff[ge]),
                  .mag_prev (mag4_ff[ge][gk]),
                  .neg_prev (neg4_ff[ge][gk]),
                  .rem_out  (rem_w[ge][gk][gj]),
                  .quo_out  (quo_w[ge][gk][gj]),
                  .s_out    (s_w[ge][gk][gj]),
                  .l_out    (l_w[ge][gk][gj]),
                  .mag_out  (mag_w[ge][gk][gj]),
                  .neg_out  (neg_w[ge][gk][gj])
               );
            end else begin : g_body
               qpq_div_cell #(.RW(SW), .MW(DW), .QW(DW), .BIT(DW - 1 - gj)) u_cell (
                  .clock    (clock),
                  .enable   (adv),
                  .rem_prev (rem_w[ge][gk][gj-1]),
                  .quo_prev (quo_w[ge][gk][gj-1]),
                  .s_prev   (s_w[ge][gk][gj-1]),
                  .l_prev   (l_w[ge][gk][gj-1]),
                  .mag_prev (mag_w[ge][gk][gj-1]),
                  .neg_prev (neg_w[ge][gk][gj-1]),
                  .rem_out  (rem_w[ge][gk][gj]),
                  .quo_out  (quo_w[ge][gk][gj]),
                  .s_out    (s_w[ge][gk][gj]),
                  .l_out    (l_w[ge][gk][gj]),
                  .mag_out  (mag_w[ge][gk][gj]),
                  .neg_out  (neg_w[ge][gk][gj])
               );
            end
         end
      end
   end

   // Side line that runs beside the divide rows with the point, the inside
   // flag and the clamp decisions.
   logic                vld_sl_ff [NCELL];
   logic signed [W-1:0] p_sl_ff   [NCELL][3];
   logic                ins_sl_ff [NCELL];
   logic                lo_sl_ff  [NCELL][NUM_CORNERS];
   logic                hi_sl_ff  [NCELL][NUM_CORNERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NCELL; j++) begin
            vld_sl_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         vld_sl_ff[0] <= v4_ff;
         for (int j = 1; j < NCELL; j++) begin
            vld_sl_ff[j] <= vld_sl_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ins_sl_ff[0] <= ins4_ff;
         for (int k = 0; k < 3; k++) begin
            p_sl_ff[0][k] <= p4_ff[k];
         end
         for (int i = 0; i < NUM_CORNERS; i++) begin
            lo_sl_ff[0][i] <= lo4_ff[i];
            hi_sl_ff[0][i] <= hi4_ff[i];
         end
         for (int j = 1; j < NCELL; j++) begin
            ins_sl_ff[j] <= ins_sl_ff[j-1];
            for (int k = 0; k < 3; k++) begin
               p_sl_ff[j][k] <= p_sl_ff[j-1][k];
            end
            for (int i = 0; i < NUM_CORNERS; i++) begin
               lo_sl_ff[j][i] <= lo_sl_ff[j-1][i];
               hi_sl_ff[j][i] <= hi_sl_ff[j-1][i];
            end
         end
      end
   end

   // Candidate stage: clamp to a start or end corner, or step from the
   // start corner by the signed quotient.
   logic                vc1_ff;
   logic                ins_c1_ff;
   logic signed [W-1:0] p_c1_ff [3];
   logic signed [W-1:0] cand_c1_ff [NUM_CORNERS][3];
   logic signed [EW-1:0] qs, cval;

   function automatic logic signed [W-1:0] cand_step(input logic signed [W-1:0] start,
                                                     input logic [DW-1:0] quo,
                                                     input logic neg);
      logic signed [EW-1:0] q_ext;
      logic signed [EW-1:0] sum;
      q_ext = $signed(EW'(quo));
      sum   = EW'(start) + (neg ? -q_ext : q_ext);
      return sum[W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vc1_ff <= 1'b0;
      end else if (adv) begin
         vc1_ff <= vld_sl_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ins_c1_ff <= ins_sl_ff[LAST];
         for (int k = 0; k < 3; k++) begin
            p_c1_ff[k] <= p_sl_ff[LAST][k];
         end
         for (int i = 0; i < NUM_CORNERS; i++) begin
            for (int k = 0; k < 3; k++) begin
               if (lo_sl_ff[LAST][i]) begin
                  cand_c1_ff[i][k] <= crd[i][k];
               end else if (hi_sl_ff[LAST][i]) begin
                  cand_c1_ff[i][k] <= crd[(i + 1) % NUM_CORNERS][k];
               end else begin
                  cand_c1_ff[i][k] <= cand_step(crd[i][k], quo_w[i][k][LAST],
                                                neg_w[i][k][LAST]);
               end
            end
         end
      end
   end

   assign qs   = '0;
   assign cval = qs;

   // Squared distance terms.
   logic                 vc2_ff;
   logic                 ins_c2_ff;
   logic signed [W-1:0]  cand_c2_ff [NUM_CORNERS][3];
   logic [PW-1:0]        sq_c2_ff [NUM_CORNERS][3];
   logic signed [DW-1:0] dk [NUM_CORNERS][3];

   always_comb begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         for (int k = 0; k < 3; k++) begin
            dk[i][k] = DW'(cand_c1_ff[i][k]) - DW'(p_c1_ff[k]) + DW'(cval);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc2_ff <= 1'b0;
      end else if (adv) begin
         vc2_ff <= vc1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ins_c2_ff <= ins_c1_ff;
         for (int i = 0; i < NUM_CORNERS; i++) begin
            for (int k = 0; k < 3; k++) begin
               cand_c2_ff[i][k] <= cand_c1_ff[i][k];
               sq_c2_ff[i][k]   <= PW'(dk[i][k]) * PW'(dk[i][k]);
            end
         end
      end
   end

   // Distance sums.
   logic                vc3_ff;
   logic                ins_c3_ff;
   logic signed [W-1:0] cand_c3_ff [NUM_CORNERS][3];
   logic [SW-1:0]       d_c3_ff [NUM_CORNERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vc3_ff <= 1'b0;
      end else if (adv) begin
         vc3_ff <= vc2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ins_c3_ff <= ins_c2_ff;
         for (int i = 0; i < NUM_CORNERS; i++) begin
            d_c3_ff[i] <= SW'(sq_c2_ff[i][0]) + SW'(sq_c2_ff[i][1]) + SW'(sq_c2_ff[i][2]);
            for (int k = 0; k < 3; k++) begin
               cand_c3_ff[i][k] <= cand_c2_ff[i][k];
            end
         end
      end
   end

   // First compare level: edges 0/1 and 2/3. The higher edge wins only on
   // a strictly smaller distance, so ties keep the lower edge.
   logic                  vc4_ff;
   logic                  ins_c4_ff;
   logic [SW-1:0]         dm_c4_ff [2];
   logic [EDGE_WIDTH-1:0] em_c4_ff [2];
   logic signed [W-1:0]   cm_c4_ff [2][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vc4_ff <= 1'b0;
      end else if (adv) begin
         vc4_ff <= vc3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ins_c4_ff <= ins_c3_ff;
         for (int h = 0; h < 2; h++) begin
            if (d_c3_ff[2*h+1] < d_c3_ff[2*h]) begin
               dm_c4_ff[h] <= d_c3_ff[2*h+1];
               em_c4_ff[h] <= EDGE_WIDTH'(2*h+1);
               for (int k = 0; k < 3; k++) begin
                  cm_c4_ff[h][k] <= cand_c3_ff[2*h+1][k];
               end
            end else begin
               dm_c4_ff[h] <= d_c3_ff[2*h];
               em_c4_ff[h] <= EDGE_WIDTH'(2*h);
               for (int k = 0; k < 3; k++) begin
                  cm_c4_ff[h][k] <= cand_c3_ff[2*h][k];
               end
            end
         end
      end
   end

   // Output register: final compare.
   logic                  ins_out_ff;
   logic signed [W-1:0]   near_out_ff [3];
   logic [EDGE_WIDTH-1:0] edge_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vc4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ins_out_ff <= ins_c4_ff;
         if (dm_c4_ff[1] < dm_c4_ff[0]) begin
            edge_out_ff <= em_c4_ff[1];
            for (int k = 0; k < 3; k++) begin
               near_out_ff[k] <= cm_c4_ff[1][k];
            end
         end else begin
            edge_out_ff <= em_c4_ff[0];
            for (int k = 0; k < 3; k++) begin
               near_out_ff[k] <= cm_c4_ff[0][k];
            end
         end
      end
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.inside_quad  = ins_out_ff;
   assign rsp_chan.nearest_x    = near_out_ff[0];
   assign rsp_chan.nearest_y    = near_out_ff[1];
   assign rsp_chan.nearest_z    = near_out_ff[2];
   assign rsp_chan.nearest_edge = edge_out_ff;

   // A result word only appears when the last compare stage held one.
   a_out_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(vc4_ff))
      else $error("result word appeared without a word in the compare stage");

   // While the output is blocked, no word moves or vanishes in the stages before and after the divide rows.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff, vc1_ff, vc2_ff, vc3_ff, vc4_ff}))
      else $error("pipeline valid bits changed during a stall");

   // For edge 0 and x, an unclamped quotient stays below the edge magnitude (or the magnitude is zero).
   a_quo_in_edge: assert property (@(posedge clock) disable iff (reset)
      (vld_sl_ff[LAST] && !lo_sl_ff[LAST][0] && !hi_sl_ff[LAST][0]) |->
      ((quo_w[0][0][LAST] < mag_w[0][0][LAST]) || (mag_w[0][0][LAST] == '0)))
      else $error("divide row quotient exceeds the edge length");

endmodule

`default_nettype wire

// ----- dv/quad_point_query_checker.sv -----
`timescale 1ns / 100ps

// Watches the query, result and register channels, predicts each result word
// from the corner registers and compares it with what the block returns.
module quad_point_query_checker #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   qpq_req_if.sink   req_mon,
   qpq_rsp_if.sink   rsp_mon,
   qpq_csr_if.sink   csr_mon,
   output int        fail_count,
   output int        pending_count,
   output int        result_count,
   output int        inside_count
);
   import qpq_pkg::*;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      logic                  inside_flag;
      coord_type             nx;
      coord_type             ny;
      coord_type             nz;
      logic [EDGE_WIDTH-1:0] edge_idx;
   } answer_type;

   logic [3*COORD_WIDTH-1:0] corners [NUM_CORNERS];
   answer_type               answers_due [$];

   assign pending_count = answers_due.size();

   function automatic longint crd(logic [3*COORD_WIDTH-1:0] r, int k);
      coord_type c;
      c = r[k*COORD_WIDTH +: COORD_WIDTH];
      return longint'(c);
   endfunction

   function automatic answer_type nearest_on_boundary(longint px, longint py, longint pz);
      answer_type ans;
      longint   c[4][3], p[3], rel[3], u[3], v[3], cand[3], e[3], ap[3];
      longint   su, lu, sv, lv, s, len2, d, bestd, q;
      longint   best[3];
      int       bi;
      p[0] = px; p[1] = py; p[2] = pz;
      for (int i = 0; i < 4; i++)
         for (int k = 0; k < 3; k++)
            c[i][k] = crd(corners[i], k);
      for (int k = 0; k < 3; k++) begin
         rel[k] = p[k] - c[0][k];
         u[k]   = c[1][k] - c[0][k];
         v[k]   = c[3][k] - c[0][k];
      end
      su = rel[0]*u[0] + rel[1]*u[1] + rel[2]*u[2];
      lu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
      sv = rel[0]*v[0] + rel[1]*v[1] + rel[2]*v[2];
      lv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
      ans.inside_flag = (su >= 0 && su <= lu && sv >= 0 && sv <= lv);
      bestd = 0;
      bi = 0;
      for (int i = 0; i < 4; i++) begin
         for (int k = 0; k < 3; k++) begin
            e[k]  = c[(i+1)%4][k] - c[i][k];
            ap[k] = p[k] - c[i][k];
         end
         s    = ap[0]*e[0] + ap[1]*e[1] + ap[2]*e[2];
         len2 = e[0]*e[0] + e[1]*e[1] + e[2]*e[2];
         d = 0;
         for (int k = 0; k < 3; k++) begin
            if (len2 == 0 || s <= 0) cand[k] = c[i][k];
            else if (s >= len2) cand[k] = c[(i+1)%4][k];
            else begin
               // Magnitude times s fits in 64 bits at these widths.
               q = ((e[k] < 0 ? -e[k] : e[k]) * s) / len2;
               cand[k] = c[i][k] + (e[k] < 0 ? -q : q);
            end
            d += (cand[k] - p[k]) * (cand[k] - p[k]);
         end
         if (i == 0 || d < bestd) begin
            bestd = d;
            bi = i;
            best = cand;
         end
      end
      ans.nx = coord_type'(best[0]);
      ans.ny = coord_type'(best[1]);
      ans.nz = coord_type'(best[2]);
      ans.edge_idx = EDGE_WIDTH'(bi);
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want, got;
      if (reset) begin
         for (int i = 0; i < NUM_CORNERS; i++) corners[i] <= '0;
         answers_due.delete();
         fail_count   <= 0;
         result_count <= 0;
         inside_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            answers_due.push_back(nearest_on_boundary(longint'(req_mon.query_x),
               longint'(req_mon.query_y), longint'(req_mon.query_z)));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.inside_quad, rsp_mon.nearest_x, rsp_mon.nearest_y,
                    rsp_mon.nearest_z, rsp_mon.nearest_edge};
            result_count <= result_count + 1;
            if (got.inside_flag) inside_count <= inside_count + 1;
            if (answers_due.size() == 0) begin
               $display("%0t: result word with none expected: %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (want != got) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready && csr_mon.addr < NUM_CORNERS)
            corners[csr_mon.addr[CORNER_IDX_WIDTH-1:0]] <= csr_mon.data;
      end
   end
endmodule

// ----- dv/quad_point_query_test.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the quad point query block. The checker beside the
// block does all prediction; this module only drives words and waits.
module quad_point_query_test;
   import qpq_pkg::*;

   localparam int W = 16;
   // Span from acceptance to the output register.
   localparam int LATENCY = W + 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, result_count, inside_count;
   int   phases_run;
   logic rsp_stall = 1'b0;

   qpq_req_if #(W) req_chan ();
   qpq_rsp_if #(W) rsp_chan ();
   qpq_csr_if #(W) csr_chan ();

   quad_point_query #(.COORD_WIDTH(W)) u_dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan));

   quad_point_query_checker #(.COORD_WIDTH(W)) u_checker (
      .clock(clock), .reset(reset),
      .req_mon(req_chan), .rsp_mon(rsp_chan), .csr_mon(csr_chan),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count), .inside_count(inside_count));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The receiver stalls on its own pattern: long ready stretches are mixed at
   // random with phases of random back-pressure of varying density.
   int stall_mode = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(10, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      unique case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end
   assign rsp_chan.ready = !rsp_stall;

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.query_x = '0;
      req_chan.query_y = '0;
      req_chan.query_z = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.addr    = '0;
      csr_chan.data    = '0;
   end

   // Writes one register; called only while nothing is in flight. Valid is
   // dropped again before the task returns.
   task automatic write_corner(input logic [CSR_ADDR_WIDTH-1:0] idx,
                               input logic [3*W-1:0] value);
      csr_chan.addr  <= idx;
      csr_chan.data  <= value;
      csr_chan.valid <= 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sends one query word; valid stays high when the next word follows at once.
   task automatic send_point(input logic [W-1:0] x, y, z, input bit keep_valid);
      req_chan.query_x <= x;
      req_chan.query_y <= y;
      req_chan.query_z <= z;
      req_chan.valid   <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      if (!keep_valid) req_chan.valid <= 1'b0;
   endtask

   task automatic drain_pipeline();
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [3*W-1:0] pack_pt(logic [W-1:0] x, y, z);
      return {z, y, x};
   endfunction

   // Coordinate biased toward the extremes, zero and small values.
   function automatic logic [W-1:0] pick_coord(int span);
      unique case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return '0;
         3, 4: return W'($urandom);
         default: return W'(int'($urandom_range(0, 2*span)) - span);
      endcase
   endfunction

   task automatic load_quad(input logic [3*W-1:0] a, b, c, d);
      write_corner(CSR_CORNER_A, a);
      write_corner(CSR_CORNER_B, b);
      write_corner(CSR_CORNER_C, c);
      write_corner(CSR_CORNER_D, d);
      phases_run++;
   endtask

   // Random queries in bursts with gaps; points mostly cluster near the quad.
   // With no gap the next burst follows the last word without dropping valid.
   task automatic random_queries(input int count, input int span);
      int n, burst, gap;
      n = 0;
      while (n < count) begin
         burst = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         for (int i = 0; i < burst && n < count; i++, n++)
            send_point(pick_coord(span), pick_coord(span), pick_coord(span),
                       ((i + 1 < burst) || (gap == 0)) && (n + 1 < count));
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      logic [3*W-1:0] qa, qb, qc, qd;
      int span;
      phases_run = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset corners: degenerate quad at the origin.
      send_point(16'h8000, 16'h7fff, 16'h0000, 1'b1);
      send_point(16'h1234, 16'hfedc, 16'h8000, 1'b0);
      drain_pipeline();

      // Square of side 0x100 in the xy plane; inside, outside, corners, edge ties.
      load_quad(pack_pt(0, 0, 0), pack_pt(16'h0100, 0, 0),
                pack_pt(16'h0100, 16'h0100, 0), pack_pt(0, 16'h0100, 0));
      send_point(16'h0080, 16'h0080, 16'h0000, 1'b1);
      send_point(16'h0080, 16'h0080, 16'h0500, 1'b1);
      send_point(16'h0040, 16'h0080, 16'h0000, 1'b1);
      send_point(16'hff00, 16'hff00, 16'h0000, 1'b1);
      send_point(16'h0100, 16'h0100, 16'h0000, 1'b1);
      send_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
      send_point(16'h8000, 16'h8000, 16'h8000, 1'b1);
      send_point(16'h0033, 16'h0200, 16'hffff, 1'b0);
      drain_pipeline();

      // Extreme corners with a zero-length edge between c and d.
      load_quad(pack_pt(16'h8000, 16'h8000, 16'h8000),
                pack_pt(16'h7fff, 16'h8000, 16'h7fff),
                pack_pt(16'h7fff, 16'h7fff, 16'h7fff),
                pack_pt(16'h7fff, 16'h7fff, 16'h7fff));
      send_point(16'h0000, 16'h0000, 16'h0000, 1'b1);
      send_point(16'h7fff, 16'h8000, 16'h8000, 1'b1);
      send_point(16'h8000, 16'h7fff, 16'h7fff, 1'b1);
      send_point(16'h0001, 16'hffff, 16'h4000, 1'b0);
      drain_pipeline();

      // Random quads, mostly small so that inside points are common.
      for (int ph = 0; ph < 12; ph++) begin
         span = (ph % 4 == 3) ? 32768 : (ph % 2 == 0 ? 1024 : 64);
         qa = pack_pt(pick_coord(span), pick_coord(span), pick_coord(span));
         qb = pack_pt(pick_coord(span), pick_coord(span), pick_coord(span));
         qc = (ph == 5) ? qb : pack_pt(pick_coord(span), pick_coord(span),
                                       pick_coord(span));
         qd = pack_pt(pick_coord(span), pick_coord(span), pick_coord(span));
         if (ph % 4 == 1) qd = pack_pt(qa[W-1:0], qa[2*W-1:W] + 16'h0040, qa[3*W-1:2*W]);
         load_quad(qa, qb, qc, qd);
         random_queries(128, span);
         drain_pipeline();
      end

      // An address beyond the register map must leave the corners alone.
      write_corner(CSR_ADDR_WIDTH'(NUM_CORNERS + 7), '1);
      random_queries(20, 32768);
      drain_pipeline();

      $display("Covered %0d corner settings and %0d result words, %0d of them inside.",
               phases_run, result_count, inside_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(12ns * 400000);
      $display("status: fail");
      $finish;
   end
endmodule
